/* rtl/core/lss_pkg.sv */
// shared types and codes for the link session supervisor
`timescale 1ns / 1ps

package lss_pkg;

	// field widths
	localparam int EVENT_W   = 5;
	localparam int ACTION_W  = 4;
	localparam int PHASE_W   = 3;
	localparam int ATTEMPT_W = 4;
	localparam int REASON_W  = 2;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_DISC   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CONN   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_KEY    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ONLINE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_REACQ  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SEVER  = 3'd5;

	// event codes
	localparam logic [EVENT_W-1:0] EVT_BREACH       = 5'd0;
	localparam logic [EVENT_W-1:0] EVT_TCP_UP       = 5'd1;
	localparam logic [EVENT_W-1:0] EVT_KEY_OK       = 5'd2;
	localparam logic [EVENT_W-1:0] EVT_KEY_UNKNOWN  = 5'd3;
	localparam logic [EVENT_W-1:0] EVT_KEY_MISMATCH = 5'd4;
	localparam logic [EVENT_W-1:0] EVT_AUTH_OK      = 5'd5;
	localparam logic [EVENT_W-1:0] EVT_AUTH_FAIL    = 5'd6;
	localparam logic [EVENT_W-1:0] EVT_PROBE_OK     = 5'd7;
	localparam logic [EVENT_W-1:0] EVT_PROBE_FAIL   = 5'd8;
	localparam logic [EVENT_W-1:0] EVT_FAIL         = 5'd9;
	localparam logic [EVENT_W-1:0] EVT_ABORT        = 5'd10;
	localparam logic [EVENT_W-1:0] EVT_CLOSE        = 5'd11;
	localparam logic [EVENT_W-1:0] EVT_TRUST        = 5'd12;
	localparam logic [EVENT_W-1:0] EVT_DECLINE      = 5'd13;
	localparam logic [EVENT_W-1:0] EVT_DROP         = 5'd14;
	localparam logic [EVENT_W-1:0] EVT_BACKOFF_EXP  = 5'd15;
	localparam logic [EVENT_W-1:0] EVT_RECONNECT_OK = 5'd16;

	// action codes
	localparam logic [ACTION_W-1:0] AC_NONE     = 4'd0;
	localparam logic [ACTION_W-1:0] AC_START    = 4'd1;
	localparam logic [ACTION_W-1:0] AC_AUTH     = 4'd2;
	localparam logic [ACTION_W-1:0] AC_WAITKEY  = 4'd3;
	localparam logic [ACTION_W-1:0] AC_FAILURE  = 4'd4;
	localparam logic [ACTION_W-1:0] AC_PROBE    = 4'd5;
	localparam logic [ACTION_W-1:0] AC_ONLINE   = 4'd6;
	localparam logic [ACTION_W-1:0] AC_TEARDOWN = 4'd7;
	localparam logic [ACTION_W-1:0] AC_BACKOFF  = 4'd8;
	localparam logic [ACTION_W-1:0] AC_SEVERED  = 4'd9;

	// failure reasons
	localparam logic [REASON_W-1:0] RS_OK       = 2'd0;
	localparam logic [REASON_W-1:0] RS_MISMATCH = 2'd1;
	localparam logic [REASON_W-1:0] RS_AUTH     = 2'd2;
	localparam logic [REASON_W-1:0] RS_NOSHELL  = 2'd3;

	// budget and counter limits
	localparam logic [ATTEMPT_W-1:0] BUDGET_RESET = 4'd6;
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX  = 4'd15;
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_ONE  = 4'd1;
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_ZERO = 4'd0;

	// session state carried between items
	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [ATTEMPT_W-1:0] attempt;
		logic [REASON_W-1:0]  reason;
	} sess_state_t;

endpackage

/* rtl/core/lss_step.sv */
// next-state and action logic for one session event
`timescale 1ns / 1ps

module lss_step
	import lss_pkg::*;
(
	input  logic [EVENT_W-1:0]   event_code,
	input  sess_state_t          cur,
	input  logic [ATTEMPT_W-1:0] retry_budget,
	output logic [ACTION_W-1:0]  action_code,
	output sess_state_t          nxt
);

	logic [ATTEMPT_W-1:0] attempt_inc;
	logic                 give_up;

	// saturating retry count and budget check
	assign attempt_inc = (cur.attempt < ATTEMPT_MAX) ? cur.attempt + ATTEMPT_ONE : cur.attempt;
	assign give_up     = (attempt_inc >= retry_budget);

	// phase table
	always_comb begin
		nxt         = cur;
		action_code = AC_NONE;
		unique case (cur.phase)
			PH_DISC, PH_SEVER: begin
				if (event_code == EVT_BREACH) begin
					nxt.phase   = PH_CONN;
					nxt.attempt = ATTEMPT_ZERO;
					nxt.reason  = RS_OK;
					action_code = AC_START;
				end
			end
			PH_CONN: begin
				unique case (event_code)
					EVT_KEY_OK: action_code = AC_AUTH;
					EVT_KEY_UNKNOWN: begin
						nxt.phase   = PH_KEY;
						action_code = AC_WAITKEY;
					end
					EVT_KEY_MISMATCH: begin
						nxt.phase   = PH_DISC;
						nxt.reason  = RS_MISMATCH;
						action_code = AC_FAILURE;
					end
					EVT_AUTH_OK: action_code = AC_PROBE;
					EVT_AUTH_FAIL: begin
						nxt.phase   = PH_DISC;
						nxt.reason  = RS_AUTH;
						action_code = AC_FAILURE;
					end
					EVT_PROBE_OK: begin
						nxt.phase   = PH_ONLINE;
						nxt.attempt = ATTEMPT_ZERO;
						action_code = AC_ONLINE;
					end
					EVT_PROBE_FAIL: begin
						nxt.phase   = PH_DISC;
						nxt.reason  = RS_NOSHELL;
						action_code = AC_FAILURE;
					end
					EVT_FAIL: begin
						nxt.phase   = PH_DISC;
						action_code = AC_FAILURE;
					end
					EVT_ABORT, EVT_CLOSE: begin
						nxt.phase   = PH_DISC;
						action_code = AC_TEARDOWN;
					end
					default: action_code = AC_NONE;
				endcase
			end
			PH_KEY: begin
				unique case (event_code)
					EVT_TRUST: begin
						nxt.phase   = PH_CONN;
						action_code = AC_AUTH;
					end
					EVT_DECLINE, EVT_ABORT: begin
						nxt.phase   = PH_DISC;
						action_code = AC_TEARDOWN;
					end
					default: action_code = AC_NONE;
				endcase
			end
			PH_ONLINE: begin
				unique case (event_code)
					EVT_DROP, EVT_FAIL: begin
						nxt.phase   = PH_REACQ;
						nxt.attempt = ATTEMPT_ONE;
						action_code = AC_BACKOFF;
					end
					EVT_CLOSE: begin
						nxt.phase   = PH_DISC;
						action_code = AC_TEARDOWN;
					end
					default: action_code = AC_NONE;
				endcase
			end
			PH_REACQ: begin
				unique case (event_code)
					EVT_BACKOFF_EXP: action_code = AC_START;
					EVT_KEY_OK:      action_code = AC_AUTH;
					EVT_KEY_UNKNOWN: begin
						nxt.phase   = PH_KEY;
						action_code = AC_WAITKEY;
					end
					EVT_KEY_MISMATCH: begin
						nxt.phase   = PH_DISC;
						nxt.reason  = RS_MISMATCH;
						action_code = AC_FAILURE;
					end
					EVT_AUTH_OK: action_code = AC_PROBE;
					EVT_PROBE_OK, EVT_RECONNECT_OK: begin
						nxt.phase   = PH_ONLINE;
						nxt.attempt = ATTEMPT_ZERO;
						action_code = AC_ONLINE;
					end
					EVT_AUTH_FAIL, EVT_PROBE_FAIL, EVT_FAIL, EVT_DROP: begin
						if (event_code == EVT_AUTH_FAIL) begin
							nxt.reason = RS_AUTH;
						end else if (event_code == EVT_PROBE_FAIL) begin
							nxt.reason = RS_NOSHELL;
						end
						nxt.attempt = attempt_inc;
						if (give_up) begin
							nxt.phase   = PH_SEVER;
							action_code = AC_SEVERED;
						end else begin
							action_code = AC_BACKOFF;
						end
					end
					EVT_ABORT, EVT_CLOSE: begin
						nxt.phase   = PH_DISC;
						action_code = AC_TEARDOWN;
					end
					default: action_code = AC_NONE;
				endcase
			end
			default: action_code = AC_NONE;
		endcase
	end

endmodule

/* rtl/core/link_session_supervisor_top.sv */
// link session supervisor: input register, event logic, result register
// Usage:
//   Event items enter on in_valid/in_stall with event_code; an item is taken
//   at a clock edge with in_valid high and in_stall low. Each item yields
//   exactly one result item on out_valid/out_stall carrying action_code and
//   the phase, attempt count and reason as they stand after the event.
//   An accepted item passes the input register, then the result register,
//   which raises out_valid; the result is taken when out_stall is low.
//   Throughput is one item per cycle while out_stall is low: the session state is
//   updated in the same cycle the item moves from the input register into
//   the result register, so the next item sees it at once.
//   When the receiver holds out_stall, the result register holds, the input
//   register fills and in_stall rises while both are occupied.
//   retry_budget is written on cfg_valid/cfg_ready (always ready); the user
//   must write it only while the block is idle, which the block does not enforce.
//   Reset puts the phase at disconnected, the attempt count and reason at
//   zero, the budget at six, and empties both registers.
`timescale 1ns / 1ps

module link_session_supervisor_top
	import lss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [EVENT_W-1:0]   event_code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ACTION_W-1:0]  action_code,
	output logic [PHASE_W-1:0]   phase_now,
	output logic [ATTEMPT_W-1:0] attempt_now,
	output logic [REASON_W-1:0]  reason_now,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ATTEMPT_W-1:0] retry_budget
);

	logic                 valid_s1;
	logic [EVENT_W-1:0]   event_s1;
	logic                 valid_s2;
	logic [ACTION_W-1:0]  action_s2;
	sess_state_t          result_s2;
	sess_state_t          state_q;
	sess_state_t          state_nxt;
	logic [ATTEMPT_W-1:0] budget_q;
	logic [ACTION_W-1:0]  action_nxt;
	logic                 adv;
	logic                 in_take;

	// handshake
	assign adv       = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			budget_q <= retry_budget;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			event_s1 <= event_code;
		end
	end

	// event logic
	lss_step u_step (
		.event_code   (event_s1),
		.cur          (state_q),
		.retry_budget (budget_q),
		.action_code  (action_nxt),
		.nxt          (state_nxt)
	);

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_DISC, attempt: ATTEMPT_ZERO, reason: RS_OK};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= action_nxt;
			result_s2 <= state_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign action_code = action_s2;
	assign phase_now   = result_s2.phase;
	assign attempt_now = result_s2.attempt;
	assign reason_now  = result_s2.reason;

	// checks
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (phase_now == state_q.phase && attempt_now == state_q.attempt
			&& reason_now == state_q.reason))
		else $error("result register differs from session state");

	a_severed_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action_code == AC_SEVERED) |-> (phase_now == PH_SEVER))
		else $error("severed action without severed phase");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held item");

	a_online_clears_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action_code == AC_ONLINE) |-> (attempt_now == ATTEMPT_ZERO))
		else $error("online without cleared attempt count");

endmodule
